// File: src/ncm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncm_pkg: shared constants, types and cosine table
// Widths, register indexes and the quarter-wave cosine table used by the
// NCO complex mixer.
// ----------------------------------------------------------------------------
package ncm_pkg;

	localparam int TABLE_SIZE  = 256;
	localparam int IDX_W       = $clog2(TABLE_SIZE);
	localparam int QUARTER     = TABLE_SIZE / 4;
	localparam int QTR_IDX_W   = $clog2(QUARTER + 1);
	localparam int LUT_W       = 16;
	localparam int LUT_FRAC    = 15;
	localparam int SAMPLE_BITS = 16;
	localparam int BAND_W      = 9;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam int REG_IDX_W = APB_AW - 2;
	localparam logic [REG_IDX_W-1:0] REG_BAND = REG_IDX_W'(0);

	localparam logic [LUT_W-1:0] QCOS [QUARTER+1] = '{
		16'd32768, 16'd32758, 16'd32729, 16'd32679, 16'd32610, 16'd32522, 16'd32413, 16'd32286,
		16'd32138, 16'd31972, 16'd31786, 16'd31581, 16'd31357, 16'd31114, 16'd30853, 16'd30572,
		16'd30274, 16'd29957, 16'd29622, 16'd29269, 16'd28899, 16'd28511, 16'd28106, 16'd27684,
		16'd27246, 16'd26791, 16'd26320, 16'd25833, 16'd25330, 16'd24812, 16'd24279, 16'd23732,
		16'd23170, 16'd22595, 16'd22006, 16'd21403, 16'd20788, 16'd20160, 16'd19520, 16'd18868,
		16'd18205, 16'd17531, 16'd16846, 16'd16151, 16'd15447, 16'd14733, 16'd14010, 16'd13279,
		16'd12540, 16'd11793, 16'd11039, 16'd10279, 16'd9512,  16'd8740,  16'd7962,  16'd7180,
		16'd6393,  16'd5602,  16'd4808,  16'd4011,  16'd3212,  16'd2411,  16'd1608,  16'd804,
		16'd0
	};

	typedef struct packed {
		logic                    valid;
		logic                    block_end;
		logic signed [LUT_W-1:0] cos_v;
		logic signed [LUT_W-1:0] sin_v;
	} lo_t;

	function automatic logic signed [LUT_W-1:0] lut_cos(input logic [IDX_W-1:0] idx);
		logic [1:0]                quad;
		logic [QTR_IDX_W-1:0]      r;
		logic [QTR_IDX_W-1:0]      rr;
		logic [LUT_W-1:0]          mag;
		logic signed [LUT_W+1:0]   v;
		quad = idx[IDX_W-1 -: 2];
		r    = {1'b0, idx[IDX_W-3:0]};
		rr   = QTR_IDX_W'(QUARTER) - r;
		mag  = (quad[0]) ? QCOS[rr] : QCOS[r];
		v    = $signed({2'b00, mag});
		if (quad == 2'd1 || quad == 2'd2) begin
			v = -v;
		end
		if (v > $signed((LUT_W+2)'(32767))) begin
			lut_cos = 16'sh7fff;
		end else begin
			lut_cos = v[LUT_W-1:0];
		end
	endfunction

endpackage

// File: src/ncm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncm_if: sample stream interfaces
// Valid/ready channels for complex input samples and mixed results.
// ----------------------------------------------------------------------------
interface ncm_in_if #(
	parameter int SAMPLE_BITS = ncm_pkg::SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] in_i;
	logic signed [SAMPLE_BITS-1:0] in_q;
	logic                          block_end;

	modport source (output valid, in_i, in_q, block_end, input ready);
	modport sink (input valid, in_i, in_q, block_end, output ready);
endinterface

interface ncm_out_if #(
	parameter int SAMPLE_BITS = ncm_pkg::SAMPLE_BITS
);
	logic                        valid;
	logic                        ready;
	logic signed [SAMPLE_BITS:0] out_i;
	logic signed [SAMPLE_BITS:0] out_q;
	logic                        out_block_end;

	modport source (output valid, out_i, out_q, out_block_end, input ready);
	modport sink (input valid, out_i, out_q, out_block_end, output ready);
endinterface

// File: src/ncm_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncm_regs: configuration registers
// APB-style register file holding the oscillator band.
// ----------------------------------------------------------------------------
module ncm_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ncm_pkg::APB_AW-1:0]  paddr,
	input  logic [ncm_pkg::APB_DW-1:0]  pwdata,
	output logic [ncm_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [ncm_pkg::BAND_W-1:0]  band
);
	logic [ncm_pkg::BAND_W-1:0]    band_q;
	logic [ncm_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          wr_en;

	assign reg_idx = paddr[ncm_pkg::APB_AW-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign band    = band_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q <= '0;
		end else if (wr_en && reg_idx == ncm_pkg::REG_BAND) begin
			band_q <= pwdata[ncm_pkg::BAND_W-1:0];
		end
	end

	always_comb begin
		case (reg_idx)
			ncm_pkg::REG_BAND: begin
				prdata = {{(ncm_pkg::APB_DW-ncm_pkg::BAND_W){band_q[ncm_pkg::BAND_W-1]}}, band_q};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end
endmodule

// File: src/ncm_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncm_phase: sample counter, oscillator phase and cosine lookup
// Registers each sample with its phase, then looks up cosine and -sine.
// ----------------------------------------------------------------------------
module ncm_phase #(
	parameter int SAMPLE_BITS = ncm_pkg::SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  logic signed [SAMPLE_BITS-1:0] in_i,
	input  logic signed [SAMPLE_BITS-1:0] in_q,
	input  logic                          in_block_end,
	input  logic [ncm_pkg::BAND_W-1:0]    band,
	output ncm_pkg::lo_t                  lo,
	output logic signed [SAMPLE_BITS-1:0] i_s2,
	output logic signed [SAMPLE_BITS-1:0] q_s2
);
	localparam int IW = ncm_pkg::IDX_W;

	logic [IW-1:0]                 cnt_q;
	logic [2*IW-1:0]               ph_full;
	logic                          accept;

	logic                          valid_s1;
	logic                          be_s1;
	logic signed [SAMPLE_BITS-1:0] i_s1;
	logic signed [SAMPLE_BITS-1:0] q_s1;
	logic [IW-1:0]                 ph_s1;
	logic [IW-1:0]                 ph_sin;

	logic                          valid_s2;
	logic                          be_s2;
	logic signed [ncm_pkg::LUT_W-1:0] cos_s2;
	logic signed [ncm_pkg::LUT_W-1:0] sin_s2;

	assign accept  = in_valid && adv;
	assign ph_full = cnt_q * band[IW-1:0];
	assign ph_sin  = ph_s1 + IW'(ncm_pkg::QUARTER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_q + IW'(1);
			end
			if (adv) begin
				valid_s1 <= in_valid;
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			be_s1  <= in_block_end;
			i_s1   <= in_i;
			q_s1   <= in_q;
			ph_s1  <= ph_full[IW-1:0];
			be_s2  <= be_s1;
			i_s2   <= i_s1;
			q_s2   <= q_s1;
			cos_s2 <= ncm_pkg::lut_cos(ph_s1);
			sin_s2 <= ncm_pkg::lut_cos(ph_sin);
		end
	end

	always_comb begin
		lo.valid     = valid_s2;
		lo.block_end = be_s2;
		lo.cos_v     = cos_s2;
		lo.sin_v     = sin_s2;
	end

	a_cnt_advance: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> cnt_q == IW'($past(cnt_q) + IW'(1)))
		else $error("sample counter did not advance on an accepted transaction");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(cnt_q))
		else $error("sample counter moved without a transaction");
endmodule

// File: src/ncm_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncm_mixer: complex multiply and rounding
// Forms the four products, then sums, rounds and registers the result.
// ----------------------------------------------------------------------------
module ncm_mixer #(
	parameter int SAMPLE_BITS = ncm_pkg::SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  ncm_pkg::lo_t                  lo,
	input  logic signed [SAMPLE_BITS-1:0] i_s2,
	input  logic signed [SAMPLE_BITS-1:0] q_s2,
	output logic                          out_valid,
	output logic signed [SAMPLE_BITS:0]   out_i,
	output logic signed [SAMPLE_BITS:0]   out_q,
	output logic                          out_block_end
);
	localparam int PW = SAMPLE_BITS + ncm_pkg::LUT_W;
	localparam int SW = PW + 1;
	localparam int FR = ncm_pkg::LUT_FRAC;

	logic                 valid_s3;
	logic                 be_s3;
	logic signed [PW-1:0] ic_s3;
	logic signed [PW-1:0] qs_s3;
	logic signed [PW-1:0] is_s3;
	logic signed [PW-1:0] qc_s3;

	logic signed [SW-1:0] sum_i;
	logic signed [SW-1:0] sum_q;

	logic                      out_valid_q;
	logic                      out_be_q;
	logic signed [SAMPLE_BITS:0] out_i_q;
	logic signed [SAMPLE_BITS:0] out_q_q;

	assign sum_i = {ic_s3[PW-1], ic_s3} - {qs_s3[PW-1], qs_s3} + SW'(1 << (FR - 1));
	assign sum_q = {is_s3[PW-1], is_s3} + {qc_s3[PW-1], qc_s3} + SW'(1 << (FR - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s3    <= lo.valid;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			be_s3    <= lo.block_end;
			ic_s3    <= i_s2 * lo.cos_v;
			qs_s3    <= q_s2 * lo.sin_v;
			is_s3    <= i_s2 * lo.sin_v;
			qc_s3    <= q_s2 * lo.cos_v;
			out_be_q <= be_s3;
			out_i_q  <= sum_i[FR+SAMPLE_BITS:FR];
			out_q_q  <= sum_q[FR+SAMPLE_BITS:FR];
		end
	end

	assign out_valid     = out_valid_q;
	assign out_i         = out_i_q;
	assign out_q         = out_q_q;
	assign out_block_end = out_be_q;
endmodule

// File: src/nco_complex_mixer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nco_complex_mixer_core: NCO-driven quadrature down-converter
// Mixes each complex sample with exp(-j*2*pi*band*n/256).
// ----------------------------------------------------------------------------
// Usage:
//   smp_in carries one complex sample (in_i, in_q) plus a block_end flag per
//   transaction; smp_out returns the mixed sample (out_i, out_q) and the
//   flag. One result comes out for every input, in order.
//   The band register sits at APB offset 0; write it only while the stream
//   is drained. Its low 8 bits set the oscillator step per sample.
//   The result reaches smp_out through four registers (input register with
//   phase, cosine table, products, sum and round).
//   Throughput: one transaction per cycle while the receiver does not
//   stall, set by the four-stage pipeline.
//   Reset clears the sample counter, the band and all stage valids; the
//   first sample after reset is mixed at phase zero.
//   When the receiver stalls with a result pending, the whole pipeline
//   holds and smp_in.ready drops in the same cycle; nothing is lost.
// ----------------------------------------------------------------------------
module nco_complex_mixer_core #(
	parameter int SAMPLE_BITS = ncm_pkg::SAMPLE_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ncm_pkg::APB_AW-1:0] paddr,
	input  logic [ncm_pkg::APB_DW-1:0] pwdata,
	output logic [ncm_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	ncm_in_if.sink                     smp_in,
	ncm_out_if.source                  smp_out
);
	logic                          adv;
	logic [ncm_pkg::BAND_W-1:0]    band;
	ncm_pkg::lo_t                  lo;
	logic signed [SAMPLE_BITS-1:0] i_s2;
	logic signed [SAMPLE_BITS-1:0] q_s2;

	assign adv          = !smp_out.valid || smp_out.ready;
	assign smp_in.ready = adv;

	ncm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.band    (band)
	);

	ncm_phase #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_phase (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (smp_in.valid),
		.in_i         (smp_in.in_i),
		.in_q         (smp_in.in_q),
		.in_block_end (smp_in.block_end),
		.band         (band),
		.lo           (lo),
		.i_s2         (i_s2),
		.q_s2         (q_s2)
	);

	ncm_mixer #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mixer (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.lo            (lo),
		.i_s2          (i_s2),
		.q_s2          (q_s2),
		.out_valid     (smp_out.valid),
		.out_i         (smp_out.out_i),
		.out_q         (smp_out.out_q),
		.out_block_end (smp_out.out_block_end)
	);

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(smp_out.valid && !smp_out.ready) |-> !smp_in.ready)
		else $error("input taken while a result is stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!smp_out.valid |-> smp_in.ready)
		else $error("input refused while the result register is empty");
endmodule
